// ----- rtl/bounded_array_deque_unit_macros.svh -----
// assertion macros for the deque unit
`ifndef BOUNDED_ARRAY_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_ARRAY_DEQUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BDQ_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define BDQ_ASSERT_SAME(label, clk, rst_n, pre, post)
`define BDQ_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- rtl/bdq_pkg.sv -----
package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CAP_W      = 5;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_STATUS     = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // what one cell does this cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TAKE_PREV,
        OP_TAKE_NEXT
    } cell_op_t;

    function automatic word_t to_word(logic signed [31:0] v);
        return word_t'(v);
    endfunction

    function automatic logic signed [31:0] from_word(word_t w);
        return 32'(w);
    endfunction

endpackage

// ----- rtl/bdq_cell.sv -----
module bdq_cell
    import bdq_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  word_t    load_word,
    input  word_t    prev_word,
    input  word_t    next_word,
    output word_t    slot
);

    word_t slot_reg;
    word_t slot_next;

    always_comb
    begin
        unique case (op)
            OP_LOAD:      slot_next = load_word;
            OP_TAKE_PREV: slot_next = prev_word;
            OP_TAKE_NEXT: slot_next = next_word;
            default:      slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ----- rtl/bounded_array_deque_unit.sv -----
// a result word is registered from its request word on the edge that takes the request
// throughput: one request per cycle while s_tready is high; slots update in that cycle
// s_tready stays high while the result register is empty or being drained
// reset: entry count cleared, capacity set to the full depth, result register empty;
// slot contents are left as they are and only slots below the count are ever read
`include "bounded_array_deque_unit_macros.svh"

module bounded_array_deque_unit
    import bdq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func[2:0], push_value[34:3], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // front_value[31:0], removed_value[63:32],
                                   // entry_count[68:64], is_empty[69], is_full[70],
                                   // status[72:71], zero fill
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] eff_cap;
    logic             accept;
    logic             is_full_now;
    logic             is_empty_now;
    logic             push_refused;
    func_t            func;
    word_t            in_word;
    word_t            slot_q [DEPTH];

    logic             shift_back;
    logic             shift_front;
    logic             load_back;
    status_t          status_next;
    logic signed [31:0] removed_next;
    logic signed [31:0] front_next;

    logic             m_valid_reg;
    logic signed [31:0] front_reg;
    logic signed [31:0] removed_reg;
    logic [4:0]       count_out_reg;
    logic             empty_reg;
    logic             full_reg;
    status_t          status_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign func     = func_t'(s_tdata[2:0]);
    assign in_word  = to_word(s_tdata[34:3]);

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CNT_W'(1);
        else if (32'(cap_reg) > DEPTH)
            eff_cap = CNT_W'(DEPTH);
        else
            eff_cap = CNT_W'(cap_reg);
    end

    assign is_full_now  = count_reg >= eff_cap;
    assign is_empty_now = count_reg == '0;
    assign push_refused = accept && is_full_now &&
                          (func == FN_PUSH_FRONT || func == FN_PUSH_BACK);

    always_comb
    begin
        shift_back   = 1'b0;
        shift_front  = 1'b0;
        load_back    = 1'b0;
        status_next  = ST_DONE;
        removed_next = '0;
        count_next   = count_reg;
        unique case (func)
            FN_PUSH_FRONT:
            begin
                if (is_full_now)
                    status_next = ST_FULL;
                else
                begin
                    shift_back = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_PUSH_BACK:
            begin
                if (is_full_now)
                    status_next = ST_FULL;
                else
                begin
                    load_back  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_POP_FRONT:
            begin
                if (is_empty_now)
                    status_next = ST_EMPTY;
                else
                begin
                    shift_front  = accept;
                    removed_next = from_word(slot_q[0]);
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            FN_POP_BACK:
            begin
                if (is_empty_now)
                    status_next = ST_EMPTY;
                else
                    count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // front after the operation, taken from what slot 0 is about to hold
    always_comb
    begin
        if (count_next == '0)
            front_next = '0;
        else if (func == FN_PUSH_FRONT && !is_full_now)
            front_next = from_word(in_word);
        else if (func == FN_POP_FRONT && !is_empty_now)
            front_next = from_word(slot_q[1]);
        else if (func == FN_PUSH_BACK && is_empty_now)
            front_next = from_word(in_word);
        else
            front_next = from_word(slot_q[0]);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_op_t op;
        word_t    prev_w;
        word_t    next_w;

        if (i == 0)
        begin : g_first
            assign prev_w = in_word;
        end
        else
        begin : g_prev
            assign prev_w = slot_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_next
            assign next_w = slot_q[i+1];
        end

        always_comb
        begin
            if (shift_back)
                op = OP_TAKE_PREV;
            else if (shift_front)
                op = OP_TAKE_NEXT;
            else if (load_back && count_reg == CNT_W'(i))
                op = OP_LOAD;
            else
                op = OP_HOLD;
        end

        bdq_cell u_cell (
            .clk       (clk),
            .op        (op),
            .load_word (in_word),
            .prev_word (prev_w),
            .next_word (next_w),
            .slot      (slot_q[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_W'(DEPTH);
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (accept)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_reg     <= front_next;
            removed_reg   <= removed_next;
            count_out_reg <= 5'(count_next);
            empty_reg     <= count_next == '0;
            full_reg      <= count_next >= eff_cap;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, status_reg, full_reg, empty_reg, count_out_reg,
                       removed_reg, front_reg};

    `BDQ_ASSERT_SAME(a_count_in_range, clk, rst_n, 1'b1, 32'(count_reg) <= DEPTH)
    `BDQ_ASSERT_NEXT(a_count_only_on_accept, clk, rst_n, !accept, $stable(count_reg))
    `BDQ_ASSERT_NEXT(a_refused_push_holds, clk, rst_n, push_refused, count_reg == $past(count_reg))
    `BDQ_ASSERT_SAME(a_empty_matches_count, clk, rst_n, m_valid_reg, empty_reg == (count_out_reg == '0))
    `BDQ_ASSERT_NEXT(a_result_after_accept, clk, rst_n, accept, m_valid_reg)

endmodule

// ----- verif/tb_bounded_array_deque_unit.sv -----
module tb_bounded_array_deque_unit;
    import bdq_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int PHASE_ITEMS    = 140;
    localparam int LONG_HOLD      = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 12;

    typedef struct {
        logic [2:0] func;
        word_t      value;
    } deque_op_t;

    typedef struct {
        word_t      front;
        word_t      removed;
        logic [4:0] count;
        logic       empty;
        logic       full;
        status_t    status;
    } deque_view_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [79:0] m_tdata;

    // own copy of the deque contents, count and capacity register
    word_t       slot_copy [DEPTH];
    int unsigned fill_level  = 0;
    logic [4:0]  cap_setting = 5'd16;

    deque_op_t   op_queue[$];
    deque_view_t predicted_views[$];
    int          ops_issued    = 0;
    int          ops_taken     = 0;
    int          mismatches    = 0;
    int          stuck_cycles  = 0;
    int          tx_gap        = 0;
    int          rx_gap        = 0;
    int          rx_hold       = 0;
    int          stalls_wanted = 0;
    int          stalls_served = 0;
    logic        in_taken      = 1'b0;
    logic        quiet         = 1'b0;

    logic [4:0]  cap_plan [NUM_PHASES] = '{5'd2, 5'd0, 5'd1, 5'd3, 5'd16, 5'd7,
                                           5'd31, 5'd17, 5'd5, 5'd16, 5'd9, 5'd12};
    int          pct_plan [NUM_PHASES] = '{30, 60, 50, 70, 85, 40, 80, 20, 60, 50, 70, 50};

    bounded_array_deque_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic deque_view_t apply_deque_op(deque_op_t op);
        deque_view_t v;
        int unsigned cap;
        int unsigned i;
        logic        full_now;
        // register value 0 behaves as 1, anything above the depth as the depth
        cap = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
        full_now  = fill_level >= cap;
        v.removed = '0;
        v.status  = ST_DONE;
        case (op.func)
            FN_PUSH_FRONT:
                if (full_now)
                    v.status = ST_FULL;
                else
                begin
                    for (i = fill_level; i > 0; i--)
                        slot_copy[i] = slot_copy[i-1];
                    slot_copy[0] = op.value;
                    fill_level++;
                end
            FN_PUSH_BACK:
                if (full_now)
                    v.status = ST_FULL;
                else
                begin
                    slot_copy[fill_level] = op.value;
                    fill_level++;
                end
            FN_POP_FRONT:
                if (fill_level == 0)
                    v.status = ST_EMPTY;
                else
                begin
                    v.removed = slot_copy[0];
                    for (i = 0; i + 1 < fill_level; i++)
                        slot_copy[i] = slot_copy[i+1];
                    fill_level--;
                end
            FN_POP_BACK:
                if (fill_level == 0)
                    v.status = ST_EMPTY;
                else
                    fill_level--;
            default:
                ;
        endcase
        v.front = (fill_level != 0) ? slot_copy[0] : '0;
        v.count = 5'(fill_level);
        v.empty = fill_level == 0;
        v.full  = fill_level >= cap;
        return v;
    endfunction

    function automatic logic [2:0] pick_func(int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
        else if (r < 90)
            return $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
        else if (r < 96)
            return FN_STATUS;
        // codes above the status code read status only
        else
            return 3'(FN_STATUS) + 3'($urandom_range(1, 3));
    endfunction

    function automatic word_t pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s at %0t: got %h, expected %h", field, $time, got, want);
        mismatches++;
    endtask

    task automatic queue_op(logic [2:0] func, word_t value);
        deque_op_t op;
        op.func  = func;
        op.value = value;
        op_queue.push_back(op);
        ops_issued++;
    endtask

    task automatic wait_drained();
        while (ops_taken != ops_issued || predicted_views.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // request driver: holds a word until it is taken
    always @(negedge clk)
    begin
        deque_op_t op;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (!quiet && op_queue.size() != 0 && $urandom_range(0, 9) == 0)
            begin
                tx_gap = $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end
            else if (op_queue.size() != 0)
            begin
                op = op_queue.pop_front();
                s_tdata  <= {5'b0, op.value, op.func};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver with random stalls and the occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (stalls_served < stalls_wanted)
        begin
            stalls_served++;
            rx_hold = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            rx_gap = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        deque_view_t got;
        deque_view_t want;
        deque_op_t   op;
        if (rst_n)
        begin
            if (cfg_we)
                cap_setting = cfg_wdata;
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                op.func  = s_tdata[2:0];
                op.value = s_tdata[34:3];
                predicted_views.push_back(apply_deque_op(op));
                ops_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got.front   = m_tdata[31:0];
                got.removed = m_tdata[63:32];
                got.count   = m_tdata[68:64];
                got.empty   = m_tdata[69];
                got.full    = m_tdata[70];
                got.status  = status_t'(m_tdata[72:71]);
                if (predicted_views.size() == 0)
                    report_mismatch("unexpected result word", m_tdata[31:0], '0);
                else
                begin
                    want = predicted_views.pop_front();
                    if (got.front !== want.front)
                        report_mismatch("front_value", got.front, want.front);
                    if (got.removed !== want.removed)
                        report_mismatch("removed_value", got.removed, want.removed);
                    if (got.count !== want.count)
                        report_mismatch("entry_count", 32'(got.count), 32'(want.count));
                    if (got.empty !== want.empty)
                        report_mismatch("is_empty", 32'(got.empty), 32'(want.empty));
                    if (got.full !== want.full)
                        report_mismatch("is_full", 32'(got.full), 32'(want.full));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                end
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stuck_cycles <= 0;
        else if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        int ph;
        int n;
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty deque: both pops refused, status and the spare codes
        queue_op(FN_POP_FRONT, 32'sh0000_0042);
        queue_op(FN_POP_BACK, '1);
        queue_op(FN_STATUS, 32'sh1234_5678);
        for (k = 1; k <= 3; k++)
            queue_op(3'(FN_STATUS) + 3'(k), pick_value());
        // extreme values in from both ends
        queue_op(FN_PUSH_FRONT, 32'sh7FFF_FFFF);
        queue_op(FN_PUSH_BACK, 32'sh8000_0000);
        queue_op(FN_PUSH_FRONT, '0);
        queue_op(FN_PUSH_BACK, '1);
        queue_op(FN_PUSH_FRONT, 32'sh5A5A_A5A5);
        queue_op(FN_PUSH_BACK, 32'sh0000_0001);
        queue_op(FN_POP_FRONT, 32'sh7FFF_FFFF);
        queue_op(FN_POP_BACK, '0);
        queue_op(FN_POP_FRONT, '1);
        queue_op(FN_STATUS, '0);

        // first setting drops the capacity under the three words still held
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            cfg_wdata <= cap_plan[ph];
            cfg_we    <= 1'b1;
            @(negedge clk);
            cfg_we <= 1'b0;
            quiet = (ph == NUM_PHASES - 1);
            if (ph == 4)
                stalls_wanted++;
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_op(pick_func(pct_plan[ph]), pick_value());
        end

        wait_drained();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && predicted_views.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
